// File: rtl/gf3_pkg.sv
// Shared widths, kernel weights, stage types and the convolution function of the gradient filter.
package gf3_pkg;

  localparam int PIXEL_W    = 8;
  localparam int GRAD_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 13;
  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WCNT_W     = COL_W + 1;
  localparam int LINE_W     = 2 * PIXEL_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int ACC_W      = 16;

  localparam logic [ROW_W-1:0] HEIGHT_LIMIT = ROW_W'(4096);

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(480);
  localparam logic                  FAMILY_RESET = 1'b0;
  localparam logic [1:0]            DIR_RESET    = 2'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_FAMILY    = 2'd2,
    REG_DIRECTION = 2'd3
  } cfg_reg_t;

  // 3x3 window, entry row*3+col, col 2 is the newest column
  typedef logic [8:0][PIXEL_W-1:0] win_t;

  // Weights by family (Sobel, Scharr), direction (anti-diag, x, y, diag), tap
  localparam logic signed [4:0] WEIGHTS [2][4][9] = '{
    '{
      '{ 5'sd0, -5'sd2, -5'sd2, 5'sd2, 5'sd0, -5'sd2, 5'sd2, 5'sd2, 5'sd0 },
      '{ -5'sd1, 5'sd0, 5'sd1, -5'sd2, 5'sd0, 5'sd2, -5'sd1, 5'sd0, 5'sd1 },
      '{ -5'sd1, -5'sd2, -5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd2, 5'sd1 },
      '{ -5'sd2, -5'sd2, 5'sd0, -5'sd2, 5'sd0, 5'sd2, 5'sd0, 5'sd2, 5'sd2 }
    },
    '{
      '{ 5'sd0, -5'sd2, -5'sd2, 5'sd2, 5'sd0, -5'sd2, 5'sd2, 5'sd2, 5'sd0 },
      '{ -5'sd3, 5'sd0, 5'sd3, -5'sd10, 5'sd0, 5'sd10, -5'sd3, 5'sd0, 5'sd3 },
      '{ -5'sd3, -5'sd10, -5'sd3, 5'sd0, 5'sd0, 5'sd0, 5'sd3, 5'sd10, 5'sd3 },
      '{ -5'sd2, -5'sd2, 5'sd0, -5'sd2, 5'sd0, 5'sd2, 5'sd0, 5'sd2, 5'sd2 }
    }
  };

  // Line stage to window stage
  typedef struct packed {
    logic               valid;
    logic [PIXEL_W-1:0] top;
    logic [PIXEL_W-1:0] mid;
    logic [PIXEL_W-1:0] bot;
    logic               col_zero;
    logic               emit_main;
    logic               emit_tail;
    logic               drain;
  } s1_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic                     last_in_run;
    logic                     frame_end;
  } res_t;

  // Window stage to result queue: up to two results per request
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  // Signed 3x3 correlation of the window with the selected kernel
  function automatic logic signed [GRAD_W-1:0] gf3_conv(win_t win, logic fam, logic [1:0] dir);
    logic signed [ACC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < 9; i++) begin
      acc = acc + ACC_W'($signed({1'b0, win[i]})) * ACC_W'(WEIGHTS[fam][dir][i]);
    end
    return $signed(acc[GRAD_W-1:0]);
  endfunction

endpackage

// File: rtl/gf3_if.sv
// Valid/ready stream interfaces for the pixel requests and the gradient results.
interface gf3_pix_if;
  import gf3_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface gf3_res_if;
  import gf3_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] gradient;
  logic                     last_in_run;
  logic                     frame_end;
  modport source (output valid, output gradient, output last_in_run, output frame_end,
                  input ready);
  modport sink (input valid, input gradient, input last_in_run, input frame_end,
                output ready);
endinterface

// File: rtl/gradient_filter_3x3_core.sv
// Top level of the 3x3 Sobel/Scharr gradient filter.
//
// Usage: pixels arrive in raster order on the pix channel (valid/ready), one
// request per accepted pixel. Results leave on the res channel: the signed
// 3x3 gradient with a zero border, a last_in_run flag on the final result of
// a request and frame_end on the frame's last result. After the image rows,
// image_width more requests drain the last row; their pixel values are ignored.
// Registers are written through cfg_we/cfg_index/cfg_data while the block is idle.
//
// Throughput: one pixel per cycle while the result queue has room; a row-end
// request gives two results, and the single result port moves one per cycle.
// Path: a request is held in the first stage register, then its results are
// written into the result queue and shown on res; the second result of a
// row-end request is written together with the first and leaves after it.
// Reset: counters, window and queue clear at once; the line memory is then
// cleared over all MAX_WIDTH (4096) entries, during which pix.ready stays low.
// Stall: a four-entry result queue takes results while res.ready is low; the
// input is held off once fewer than two entries are free.
module gradient_filter_3x3_core (
  input  logic                              clk,
  input  logic                              rst,
  gf3_pix_if.sink                           pix,
  gf3_res_if.source                         res,
  input  logic                              cfg_we,
  input  logic [gf3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gf3_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gf3_pkg::*;

  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;
  logic                  kernel_family;
  logic [1:0]            kernel_direction;

  s1_t   s1;
  push_t push;
  logic  advance;
  logic  room;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= WIDTH_RESET;
      image_height     <= HEIGHT_RESET;
      kernel_family    <= FAMILY_RESET;
      kernel_direction <= DIR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:     image_width      <= cfg_data;
        REG_HEIGHT:    image_height     <= cfg_data;
        REG_FAMILY:    kernel_family    <= cfg_data[0];
        REG_DIRECTION: kernel_direction <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  gf3_line_stage u_line (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .image_width  (image_width),
    .image_height (image_height),
    .advance      (advance),
    .s1           (s1)
  );

  gf3_window_conv u_win (
    .clk              (clk),
    .rst              (rst),
    .s1               (s1),
    .kernel_family    (kernel_family),
    .kernel_direction (kernel_direction),
    .room             (room),
    .advance          (advance),
    .push             (push)
  );

  gf3_res_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule

// File: rtl/gf3_line_stage.sv
// Input acceptance, row/column counters, two-line pixel memory with clearing pass.
module gf3_line_stage (
  input  logic                        clk,
  input  logic                        rst,
  gf3_pix_if.sink                     pix,
  input  logic [gf3_pkg::CFG_DATA_W-1:0] image_width,
  input  logic [gf3_pkg::CFG_DATA_W-1:0] image_height,
  input  logic                        advance,
  output gf3_pkg::s1_t                s1
);
  import gf3_pkg::*;

  // Line memory: upper line in the high byte, middle line in the low byte
  logic [LINE_W-1:0] mem [MAX_WIDTH];
  logic [LINE_W-1:0] rd_q;

  logic              clr_busy;
  logic [COL_W-1:0]  clr_addr;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  logic [31:0]       w_ext;
  logic [WCNT_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic              last_col;
  logic              drain;
  logic              accept;

  // First stage registers
  logic               s1_valid;
  logic [COL_W-1:0]   s1_col;
  logic [PIXEL_W-1:0] s1_bot;
  logic               s1_r1;
  logic               s1_r2;
  logic               s1_col_zero;
  logic               s1_emit_main;
  logic               s1_emit_tail;
  logic               s1_drain;
  logic               byp;
  logic [LINE_W-1:0]  byp_data;

  logic [LINE_W-1:0]  rd_eff;
  logic [PIXEL_W-1:0] top_g;
  logic [PIXEL_W-1:0] mid_g;
  logic               wr_en;

  // Clamp the configured geometry
  always_comb begin
    w_ext = 32'(image_width);
    if (w_ext == 32'd0) begin
      w_eff = WCNT_W'(1);
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(w_ext);
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (ROW_W'(image_height) > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = ROW_W'(image_height);
    end
  end

  assign last_col  = ({1'b0, col} + WCNT_W'(1)) >= w_eff;
  assign drain     = row >= h_eff;
  assign pix.ready = !clr_busy && (!s1_valid || advance);
  assign accept    = pix.valid && pix.ready;

  // Forward the write of the previous request when it hits the same column
  assign rd_eff = byp ? byp_data : rd_q;
  assign top_g  = s1_r2 ? rd_eff[LINE_W-1:PIXEL_W] : '0;
  assign mid_g  = s1_r1 ? rd_eff[PIXEL_W-1:0] : '0;
  assign wr_en  = s1_valid && advance;

  // Clear the line memory after reset, then write back the shifted lines
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[s1_col] <= {mid_g, s1_bot};
    end
    if (accept) begin
      rd_q <= mem[col];
    end
  end

  // Sweep the clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Advance the raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= drain ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // Hold the request in the first stage until the window stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col       <= col;
      s1_bot       <= drain ? '0 : pix.pixel;
      s1_r1        <= row != '0;
      s1_r2        <= row >= ROW_W'(2);
      s1_col_zero  <= col == '0;
      s1_emit_main <= (row != '0) && (col != '0);
      s1_emit_tail <= (row != '0) && last_col;
      s1_drain     <= drain;
      byp          <= wr_en && (s1_col == col);
      byp_data     <= {mid_g, s1_bot};
    end
  end

  always_comb begin
    s1.valid     = s1_valid;
    s1.top       = top_g;
    s1.mid       = mid_g;
    s1.bot       = s1_bot;
    s1.col_zero  = s1_col_zero;
    s1.emit_main = s1_emit_main;
    s1.emit_tail = s1_emit_tail;
    s1.drain     = s1_drain;
  end

endmodule

// File: rtl/gf3_window_conv.sv
// 3x3 window register and the two constant-weight convolvers per request.
module gf3_window_conv (
  input  logic           clk,
  input  logic           rst,
  input  gf3_pkg::s1_t   s1,
  input  logic           kernel_family,
  input  logic [1:0]     kernel_direction,
  input  logic           room,
  output logic           advance,
  output gf3_pkg::push_t push
);
  import gf3_pkg::*;

  win_t window;
  win_t win_base;
  win_t win_a;
  win_t win_b;
  res_t res_main;
  res_t res_tail;

  // Shift the window left and insert a new right column
  function automatic win_t shift_in(win_t w, logic [PIXEL_W-1:0] top,
                                    logic [PIXEL_W-1:0] mid, logic [PIXEL_W-1:0] bot);
    win_t n;
    n = w;
    for (int r = 0; r < 3; r++) begin
      n[r*3]     = w[r*3+1];
      n[r*3 + 1] = w[r*3+2];
    end
    n[2] = top;
    n[5] = mid;
    n[8] = bot;
    return n;
  endfunction

  assign advance  = s1.valid && room;
  assign win_base = s1.col_zero ? '0 : window;
  assign win_a    = shift_in(win_base, s1.top, s1.mid, s1.bot);
  assign win_b    = shift_in(win_a, '0, '0, '0);

  // Result for the pixel up-left, and the row-end result with a zero column
  always_comb begin
    res_main.gradient    = gf3_conv(win_a, kernel_family, kernel_direction);
    res_main.last_in_run = !s1.emit_tail;
    res_main.frame_end   = 1'b0;
    res_tail.gradient    = gf3_conv(win_b, kernel_family, kernel_direction);
    res_tail.last_in_run = 1'b1;
    res_tail.frame_end   = s1.drain;
  end

  always_comb begin
    push.count  = advance ? 2'(s1.emit_main) + 2'(s1.emit_tail) : 2'd0;
    push.first  = s1.emit_main ? res_main : res_tail;
    push.second = res_tail;
  end

  // Keep the window state of the raster
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (advance) begin
      window <= s1.emit_tail ? win_b : win_a;
    end
  end

endmodule

// File: rtl/gf3_res_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
module gf3_res_fifo (
  input  logic           clk,
  input  logic           rst,
  input  gf3_pkg::push_t push,
  output logic           room,
  gf3_res_if.source      res
);
  import gf3_pkg::*;

  res_t                 entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp;
  logic [FIFO_AW-1:0]   rp;
  logic [FIFO_AW:0]     count;
  logic                 pop;
  res_t                 head;

  assign room            = count <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign head            = entries[rp];
  assign res.valid       = count != '0;
  assign res.gradient    = head.gradient;
  assign res.last_in_run = head.last_in_run;
  assign res.frame_end   = head.frame_end;
  assign pop             = res.valid && res.ready;

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wp + FIFO_AW'(1)] <= push.second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + FIFO_AW'(push.count);
      rp    <= rp + FIFO_AW'(pop);
      count <= count + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

// File: tb/gradient_filter_3x3_core_tb.sv
// Self-checking testbench for the 3x3 Sobel/Scharr gradient filter core.
`timescale 1ns / 1ps

module gradient_filter_3x3_core_tb;
  import gf3_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_ITEMS  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int PRINT_CAP    = 200;
  localparam int CUT_MAX      = 300;

  typedef enum bit {FAM_SOBEL, FAM_SCHARR} kfam_t;
  typedef enum bit [1:0] {DIR_ANTI, DIR_X, DIR_Y, DIR_DIAG} kdir_t;
  typedef enum int {STY_NOISE, STY_BINARY, STY_VEDGE, STY_HEDGE} pix_style_t;

  // Weights by family, direction and tap (row*3+col)
  localparam int KERN_WT [2][4][9] = '{
    '{
      '{ 0, -2, -2, 2, 0, -2, 2, 2, 0 },
      '{ -1, 0, 1, -2, 0, 2, -1, 0, 1 },
      '{ -1, -2, -1, 0, 0, 0, 1, 2, 1 },
      '{ -2, -2, 0, -2, 0, 2, 0, 2, 2 }
    },
    '{
      '{ 0, -2, -2, 2, 0, -2, 2, 2, 0 },
      '{ -3, 0, 3, -10, 0, 10, -3, 0, 3 },
      '{ -3, -10, -3, 0, 0, 0, 3, 10, 3 },
      '{ -2, -2, 0, -2, 0, 2, 0, 2, 2 }
    }
  };

  // Line buffers, window and counters mirrored from the pixel stream
  class gradient_predictor;
    int unsigned        width_reg;
    int unsigned        height_reg;
    bit                 family_reg;
    bit [1:0]           dir_reg;
    logic [PIXEL_W-1:0] upper_line [MAX_WIDTH];
    logic [PIXEL_W-1:0] middle_line [MAX_WIDTH];
    logic [PIXEL_W-1:0] win [9];
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    res_t               grad_q[$];
    int                 errors;
    int                 checked;
    int                 frames;

    function new();
      width_reg  = 640;
      height_reg = 480;
      family_reg = FAM_SOBEL;
      dir_reg    = DIR_X;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors  = 0;
      checked = 0;
      frames  = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > int'(HEIGHT_LIMIT)) return int'(HEIGHT_LIMIT);
      return height_reg;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_WIDTH:     width_reg = 32'(d);
        REG_HEIGHT:    height_reg = 32'(d);
        REG_FAMILY:    family_reg = d[0];
        REG_DIRECTION: dir_reg = d[1:0];
      endcase
    endfunction

    // Shift the window left and load a new right-hand column
    function void shift_in(logic [PIXEL_W-1:0] top, logic [PIXEL_W-1:0] mid,
                           logic [PIXEL_W-1:0] bot);
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = bot;
    endfunction

    function void queue_gradient(bit last, bit fend);
      int   acc;
      res_t r;
      acc = 0;
      for (int i = 0; i < 9; i++) acc += int'(win[i]) * KERN_WT[family_reg][dir_reg][i];
      r.gradient    = acc[GRAD_W-1:0];
      r.last_in_run = last;
      r.frame_end   = fend;
      grad_q = {grad_q, r};
    endfunction

    // Advance the raster position by one accepted pixel request
    function void take_pixel(logic [PIXEL_W-1:0] px);
      int unsigned        w;
      int unsigned        h;
      bit                 drain;
      bit                 last_col;
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] mid;
      logic [PIXEL_W-1:0] bot;
      w        = eff_width();
      h        = eff_height();
      drain    = row_cnt >= h;
      last_col = col_cnt + 1 >= w;
      bot      = drain ? '0 : px;
      top      = '0;
      mid      = '0;
      if (col_cnt == 0) foreach (win[i]) win[i] = '0;
      if (col_cnt < MAX_WIDTH) begin
        if (row_cnt >= 2) top = upper_line[col_cnt];
        if (row_cnt >= 1) mid = middle_line[col_cnt];
        upper_line[col_cnt]  = mid;
        middle_line[col_cnt] = bot;
      end
      shift_in(top, mid, bot);
      if (row_cnt >= 1) begin
        if (col_cnt >= 1) queue_gradient(!last_col, 1'b0);
        // Row end: flush the last column against the zero border
        if (last_col) begin
          shift_in('0, '0, '0);
          queue_gradient(1'b1, drain);
        end
      end
      if (last_col) begin
        col_cnt = 0;
        row_cnt = drain ? 0 : row_cnt + 1;
      end else begin
        col_cnt = col_cnt + 1;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(logic signed [GRAD_W-1:0] g, logic last, logic fend);
      res_t want;
      if (grad_q.size() == 0) begin
        flag($sformatf("unexpected result: expected none, actual gradient %0d last %0b end %0b",
                       g, last, fend));
        return;
      end
      want = grad_q.pop_front();
      checked++;
      if (want.frame_end) frames++;
      if (g !== want.gradient)
        flag($sformatf("gradient: expected %0d, actual %0d", want.gradient, g));
      if (last !== want.last_in_run)
        flag($sformatf("last_in_run: expected %0b, actual %0b", want.last_in_run, last));
      if (fend !== want.frame_end)
        flag($sformatf("frame_end: expected %0b, actual %0b", want.frame_end, fend));
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gf3_pix_if pix_ch ();
  gf3_res_if res_ch ();

  gradient_filter_3x3_core uut (
    .clk       (clk),
    .rst       (rst),
    .pix       (pix_ch.sink),
    .res       (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gradient_predictor pred = new();

  pix_style_t  pix_style = STY_NOISE;
  int unsigned edge_split = 0;
  bit          edge_flip = 1'b0;
  bit          send_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned pixels_sent = 0;
  int unsigned cycle_cnt = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Track register writes, accepted pixel requests and results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) pred.set_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (res_ch.valid && res_ch.ready)
        pred.check_result(res_ch.gradient, res_ch.last_in_run, res_ch.frame_end);
      if (pix_ch.valid && pix_ch.ready) pred.take_pixel(pix_ch.pixel);
    end
  end

  // Result side: random stall bursts and one long hold-off
  initial begin : result_sink
    res_ch.ready <= 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [PIXEL_W-1:0] next_pixel();
    bit hi;
    case (pix_style)
      STY_NOISE:  return PIXEL_W'($urandom_range(0, 255));
      STY_BINARY: hi = 1'($urandom_range(0, 1));
      STY_VEDGE:  hi = (pred.col_cnt >= edge_split) ^ edge_flip;
      default:    hi = (pred.row_cnt >= edge_split) ^ edge_flip;
    endcase
    return hi ? '1 : '0;
  endfunction

  // Requests left until the counters wrap back to the frame start
  function automatic int unsigned frame_left();
    int unsigned w;
    int unsigned h;
    int unsigned row_left;
    w        = pred.eff_width();
    h        = pred.eff_height();
    row_left = (pred.col_cnt + 1 >= w) ? 1 : w - pred.col_cnt;
    if (pred.row_cnt >= h) return row_left;
    return row_left + (h - pred.row_cnt) * w;
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: return $urandom_range(1, 8);
      14, 15, 16, 17, 18: return $urandom_range(9, 32);
      default: return $urandom_range(33, 100);
    endcase
  endfunction

  function automatic void pick_style();
    pix_style = pix_style_t'($urandom_range(0, 3));
    edge_flip = 1'($urandom_range(0, 1));
    if (pix_style == STY_HEDGE) edge_split = $urandom_range(0, pred.eff_height());
    else edge_split = $urandom_range(0, pred.eff_width());
  endfunction

  // Offer one pixel request and hold it until accepted
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_items(input int unsigned n);
    repeat (n) send_pixel(next_pixel());
    pixels_sent += n;
  endtask

  // Drop valid, drain all pending results, then let the pipeline settle
  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (pred.grad_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(d);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input kfam_t fam,
                           input kdir_t dir);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_FAMILY, fam);
    write_reg(REG_DIRECTION, dir);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned left;
    int unsigned part;
    int unsigned w;
    int unsigned h;
    int unsigned kern;
    bit          tall;
    bit          hold_done;
    bit          big_done;
    rand_items = 0;
    kern       = 0;
    hold_done  = 1'b0;
    big_done   = 1'b0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_WIDTH;
    cfg_data     <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Wait out the line memory clear
    do @(negedge clk); while (!pix_ch.ready);

    // Single-pixel frames, including zero width and height taken as one
    configure(1, 1, FAM_SOBEL, DIR_X);
    send_items(frame_left());
    configure(0, 0, FAM_SCHARR, DIR_Y);
    send_items(frame_left());
    // Full-scale Scharr edge: the center gives the largest gradient
    pix_style  = STY_VEDGE;
    edge_split = 2;
    edge_flip  = 1'b0;
    configure(3, 3, FAM_SCHARR, DIR_X);
    send_items(frame_left());
    // Height beyond the limit, then shrink width and height mid-frame
    pix_style = STY_BINARY;
    configure(4, 8191, FAM_SOBEL, DIR_DIAG);
    send_items(6);
    configure(2, 1, FAM_SCHARR, DIR_ANTI);
    send_items(frame_left());

    // Random frames, mostly complete, some cut short by register changes
    while (rand_items < RANDOM_ITEMS) begin
      send_gaps   = rand_items + QUIET_ITEMS < RANDOM_ITEMS && $urandom_range(0, 3) != 0;
      sink_stalls = rand_items + QUIET_ITEMS < RANDOM_ITEMS && $urandom_range(0, 3) != 0;
      w           = pick_width();
      h           = $urandom_range(1, 5);
      if ($urandom_range(0, 15) == 0) h = 0;
      tall = $urandom_range(0, 9) == 0;
      if (tall) h = $urandom_range(4097, 8191);
      if (!hold_done && rand_items >= 500) begin
        w    = 32;
        h    = 4;
        tall = 1'b0;
      end else if (!big_done && rand_items >= 1000) begin
        // Oversize width clamps to the line length; cut the first row short
        w        = 8191;
        h        = 1;
        tall     = 1'b1;
        big_done = 1'b1;
      end
      configure(w, h, kfam_t'(kern[2]), kdir_t'(kern[1:0]));
      kern = (kern + 1) % 8;
      pick_style();
      if (!hold_done && rand_items >= 500) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      left = frame_left();
      if (tall || $urandom_range(0, 4) == 0) begin
        part = (left - 1 > 3 * pred.eff_width()) ? 3 * pred.eff_width() : left - 1;
        if (part > CUT_MAX) part = CUT_MAX;
        part = $urandom_range(1, part);
        send_items(part);
        rand_items += part;
        configure(pick_width(), $urandom_range(1, 5), kfam_t'($urandom_range(0, 1)),
                  kdir_t'($urandom_range(0, 3)));
        pick_style();
        left = frame_left();
      end
      send_items(left);
      rand_items += left;
    end

    // Drain and close out
    wait_idle();
    repeat (20) @(negedge clk);
    $display("Sent %0d pixel requests; checked %0d gradients over %0d frames",
             pixels_sent, pred.checked, pred.frames);
    $display("Covered every kernel, widths 1 to 100, zero and oversize geometry, mid-frame changes");
    if (pred.errors == 0 && pred.grad_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, gradients still pending: %0d", pred.errors, pred.grad_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
